### rtl/rlb_pkg.sv
// shared types and constants for the rgb32 layer blend
package rlb_pkg;

  localparam int PIX_W    = 8;
  localparam int COEF_W   = 16;
  localparam int LEVEL_W  = 9;
  localparam int THRESH_W = 8;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;
  localparam int CHAN_N   = 4;
  localparam int COLOR_N  = 3;

  localparam int LUMA_SHIFT = 15;
  localparam int PROD_W     = COEF_W + PIX_W;       // coef * byte
  localparam int LSUM_W     = PROD_W + 2;           // sum of three products
  localparam int LUMA_W     = LSUM_W - LUMA_SHIFT;  // 11 bits
  localparam int WPROD_W    = PIX_W + LEVEL_W;      // alpha * level
  localparam int WGT_W      = WPROD_W - 8;          // 9 bits
  localparam int OPD_W      = LUMA_W + 1;           // signed channel operand
  localparam int DPROD_W    = OPD_W + WGT_W + 1;    // signed operand * weight

  localparam logic [DPROD_W-1:0] ROUNDER    = DPROD_W'(128);
  localparam logic [PIX_W-1:0]   FULL_SCALE = PIX_W'(255);

  typedef enum logic [2:0] {
    MODE_AVG  = 3'd0,
    MODE_MUL  = 3'd1,
    MODE_ADD  = 3'd2,
    MODE_SUB  = 3'd3,
    MODE_LITE = 3'd4,
    MODE_DARK = 3'd5
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_CHROMA = 3'd1,
    REG_LEVEL  = 3'd2,
    REG_THRESH = 3'd3,
    REG_COEF_B = 3'd4,
    REG_COEF_G = 3'd5,
    REG_COEF_R = 3'd6
  } reg_idx_t;

  localparam logic [2:0]          RST_MODE   = MODE_ADD;
  localparam logic                RST_CHROMA = 1'b0;
  localparam logic [LEVEL_W-1:0]  RST_LEVEL  = LEVEL_W'(257);
  localparam logic [THRESH_W-1:0] RST_THRESH = THRESH_W'(0);
  localparam logic [COEF_W-1:0]   RST_COEF_B = COEF_W'(3736);
  localparam logic [COEF_W-1:0]   RST_COEF_G = COEF_W'(19235);
  localparam logic [COEF_W-1:0]   RST_COEF_R = COEF_W'(9798);

  typedef logic [CHAN_N-1:0][PIX_W-1:0] pix_t;

endpackage

### rtl/rlb_pair_if.sv
// input channel: one base and one overlay bgra pixel per word
interface rlb_pair_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_b;
  logic [7:0] base_g;
  logic [7:0] base_r;
  logic [7:0] base_a;
  logic [7:0] over_b;
  logic [7:0] over_g;
  logic [7:0] over_r;
  logic [7:0] over_a;

  modport source (output valid, base_b, base_g, base_r, base_a,
                  over_b, over_g, over_r, over_a, input ready);
  modport sink   (input valid, base_b, base_g, base_r, base_a,
                  over_b, over_g, over_r, over_a, output ready);
endinterface

### rtl/rlb_pix_if.sv
// output channel: one blended bgra pixel per word
interface rlb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_b;
  logic [7:0] out_g;
  logic [7:0] out_r;
  logic [7:0] out_a;

  modport source (output valid, out_b, out_g, out_r, out_a, input ready);
  modport sink   (input valid, out_b, out_g, out_r, out_a, output ready);
endinterface

### rtl/rgb32_layer_blend.sv
// top level: five-stage pipelined bgra layer blender with config registers
//
//  channel  | dir | words
//  ---------+-----+---------------------------------------------
//  pair     | in  | base b,g,r,a and overlay b,g,r,a bytes
//  pix      | out | blended b,g,r,a bytes
//  cfg_*    | in  | register writes: we, index, 16-bit data
//
//  one word enters per cycle while pix keeps up; the edge that accepts a word
//  loads stage 1, and the word then passes in order through the five register
//  stages (products, luma sums, channel operands, weight multiply, final add /
//  output register) to pix
//  rst is synchronous and clears the stage valid bits and config registers
//  each stage holds while the next one is full and stalled, so a stall on
//  pix backs up stage by stage and ready on pair falls only when all are full
module rgb32_layer_blend
  import rlb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rlb_pair_if.sink         pair,
  rlb_pix_if.source        pix,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // configuration registers
  logic [2:0]                       blend_mode;
  logic                             chroma_on;
  logic [LEVEL_W-1:0]               level;
  logic [THRESH_W-1:0]              thresh;
  logic [COLOR_N-1:0][COEF_W-1:0]   coef;   // b, g, r

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= RST_MODE;
      chroma_on  <= RST_CHROMA;
      level      <= RST_LEVEL;
      thresh     <= RST_THRESH;
      coef[0]    <= RST_COEF_B;
      coef[1]    <= RST_COEF_G;
      coef[2]    <= RST_COEF_R;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   blend_mode <= cfg_data[2:0];
        REG_CHROMA: chroma_on  <= cfg_data[0];
        REG_LEVEL:  level      <= cfg_data[LEVEL_W-1:0];
        REG_THRESH: thresh     <= cfg_data[THRESH_W-1:0];
        REG_COEF_B: coef[0]    <= cfg_data[COEF_W-1:0];
        REG_COEF_G: coef[1]    <= cfg_data[COEF_W-1:0];
        REG_COEF_R: coef[2]    <= cfg_data[COEF_W-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // stage handshake: a stage takes a word when it is empty or drains
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

  assign s5_rdy     = !s5_valid || pix.ready;
  assign s4_rdy     = !s4_valid || s5_rdy;
  assign s3_rdy     = !s3_valid || s4_rdy;
  assign s2_rdy     = !s2_valid || s3_rdy;
  assign s1_rdy     = !s1_valid || s2_rdy;
  assign pair.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid <= pair.valid;
      if (s2_rdy) s2_valid <= s1_valid;
      if (s3_rdy) s3_valid <= s2_valid;
      if (s4_rdy) s4_valid <= s3_valid;
      if (s5_rdy) s5_valid <= s4_valid;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: luma partial products and alpha * level
  // ---------------------------------------------------------------
  pix_t in_base, in_over;
  assign in_base = {pair.base_a, pair.base_r, pair.base_g, pair.base_b};
  assign in_over = {pair.over_a, pair.over_r, pair.over_g, pair.over_b};

  pix_t                              s1_base, s1_over;
  logic [COLOR_N-1:0][PROD_W-1:0]    s1_pb, s1_po, s1_pi;
  logic [WPROD_W-1:0]                s1_wp;

  always_ff @(posedge clk) begin
    if (pair.valid && s1_rdy) begin
      s1_base <= in_base;
      s1_over <= in_over;
      for (int j = 0; j < COLOR_N; j++) begin
        s1_pb[j] <= coef[j] * in_base[j];
        s1_po[j] <= coef[j] * in_over[j];
        s1_pi[j] <= coef[j] * (FULL_SCALE - in_over[j]);   // inverted overlay
      end
      s1_wp <= in_over[3] * level;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: luma sums and weight
  // ---------------------------------------------------------------
  logic [LSUM_W-1:0]  sum_b, sum_o, sum_i;
  logic [WPROD_W-1:0] wp_rnd;

  always_comb begin
    sum_b  = LSUM_W'(s1_pb[0]) + LSUM_W'(s1_pb[1]) + LSUM_W'(s1_pb[2]);
    sum_o  = LSUM_W'(s1_po[0]) + LSUM_W'(s1_po[1]) + LSUM_W'(s1_po[2]);
    sum_i  = LSUM_W'(s1_pi[0]) + LSUM_W'(s1_pi[1]) + LSUM_W'(s1_pi[2]);
    wp_rnd = s1_wp + WPROD_W'(1);  // 255*511+1 stays inside the width
  end

  pix_t              s2_base, s2_over;
  logic [LUMA_W-1:0] s2_ly_base, s2_ly_over, s2_ly_inv;
  logic [WGT_W-1:0]  s2_w;

  always_ff @(posedge clk) begin
    if (s1_valid && s2_rdy) begin
      s2_base    <= s1_base;
      s2_over    <= s1_over;
      s2_ly_base <= sum_b[LSUM_W-1:LUMA_SHIFT];
      s2_ly_over <= sum_o[LSUM_W-1:LUMA_SHIFT];
      s2_ly_inv  <= sum_i[LSUM_W-1:LUMA_SHIFT];
      s2_w       <= wp_rnd[WPROD_W-1:8];
    end
  end

  // ---------------------------------------------------------------
  // stage 3: per-channel signed operand, gated weight, average
  // ---------------------------------------------------------------
  logic [CHAN_N-1:0][OPD_W-1:0]       opd;
  logic [CHAN_N-1:0][PIX_W-1:0]       avg;
  logic [LUMA_W-1:0]                  s_dir, s_inv;
  logic [LUMA_W+PIX_W-1:0]            sb;
  logic [PIX_W:0]                     avg_sum;
  logic [OPD_W-1:0]                   base_x;
  logic [OPD_W-1:0]                   lo_x, lb_x, th_x;
  logic                               pass;
  logic [WGT_W-1:0]                   w_sel;

  always_comb begin
    lo_x = OPD_W'(s2_ly_over);
    lb_x = OPD_W'(s2_ly_base);
    th_x = OPD_W'(thresh);
    // lighten / darken keep the weight only past the luma margin
    unique case (blend_mode)
      MODE_LITE: pass = lo_x > lb_x + th_x;
      MODE_DARK: pass = lo_x + th_x < lb_x;
      default:   pass = 1'b1;
    endcase
    w_sel = pass ? s2_w : '0;

    for (int k = 0; k < CHAN_N; k++) begin
      base_x  = OPD_W'(s2_base[k]);
      s_dir   = chroma_on ? LUMA_W'(s2_over[k]) : s2_ly_over;
      s_inv   = chroma_on ? LUMA_W'(FULL_SCALE - s2_over[k]) : s2_ly_inv;
      sb      = s_dir * s2_base[k];
      avg_sum = (PIX_W+1)'(s2_base[k]) + (PIX_W+1)'(s2_over[k]) + (PIX_W+1)'(1);
      avg[k]  = avg_sum[PIX_W:1];
      unique case (blend_mode)
        MODE_MUL:  opd[k] = OPD_W'(sb[LUMA_W+PIX_W-1:8]) - base_x;
        MODE_ADD:  opd[k] = OPD_W'(s_dir) - base_x;
        MODE_SUB:  opd[k] = OPD_W'(s_inv) - base_x;
        default:   opd[k] = OPD_W'(s2_over[k]) - base_x;
      endcase
    end
  end

  pix_t                          s3_base, s3_avg;
  logic [CHAN_N-1:0][OPD_W-1:0]  s3_opd;
  logic [WGT_W-1:0]              s3_w;

  always_ff @(posedge clk) begin
    if (s2_valid && s3_rdy) begin
      s3_base <= s2_base;
      s3_avg  <= avg;
      s3_opd  <= opd;
      s3_w    <= w_sel;
    end
  end

  // ---------------------------------------------------------------
  // stage 4: signed operand * weight plus rounding (none in multiply mode);
  // keep bits 15:8, which are the low byte of the floor shift by 8
  // ---------------------------------------------------------------
  logic [CHAN_N-1:0][DPROD_W-1:0] dprod;
  logic [DPROD_W-1:0]             rnd;

  always_comb begin
    rnd = (blend_mode == MODE_MUL) ? '0 : ROUNDER;
    for (int k = 0; k < CHAN_N; k++) begin
      dprod[k] = DPROD_W'($signed(s3_opd[k]) * $signed({1'b0, s3_w})) + rnd;
    end
  end

  pix_t s4_base, s4_avg, s4_delta;

  always_ff @(posedge clk) begin
    if (s3_valid && s4_rdy) begin
      s4_base <= s3_base;
      s4_avg  <= s3_avg;
      for (int k = 0; k < CHAN_N; k++) begin
        s4_delta[k] <= dprod[k][15:8];
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 5: output register, sums wrap modulo 256
  // ---------------------------------------------------------------
  pix_t res;

  always_comb begin
    for (int k = 0; k < CHAN_N; k++) begin
      unique case (blend_mode)
        MODE_AVG:  res[k] = s4_avg[k];
        MODE_MUL, MODE_ADD, MODE_SUB, MODE_LITE, MODE_DARK:
                   res[k] = s4_base[k] + s4_delta[k];
        default:   res[k] = s4_base[k];  // unused codes pass the base through
      endcase
    end
  end

  pix_t s5_pix;

  always_ff @(posedge clk) begin
    if (s4_valid && s5_rdy) begin
      s5_pix <= res;
    end
  end

  assign pix.valid = s5_valid;
  assign pix.out_b = s5_pix[0];
  assign pix.out_g = s5_pix[1];
  assign pix.out_r = s5_pix[2];
  assign pix.out_a = s5_pix[3];

endmodule

### rtl/rlb_check.sv
// port-level checks for the layer blender, bound to the top level
module rlb_check
  import rlb_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             pair_valid,
  input logic             pair_ready,
  input logic             pix_valid,
  input logic             pix_ready,
  input logic [PIX_W-1:0] out_b,
  input logic [PIX_W-1:0] out_g,
  input logic [PIX_W-1:0] out_r,
  input logic [PIX_W-1:0] out_a
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(out_b) && $stable(out_g)
      && $stable(out_r) && $stable(out_a))
    else $error("stalled output word changed");

  // nothing leaves right after reset and the input is open
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !pix_valid && pair_ready)
    else $error("pipeline not empty after reset");

  // input backpressure only comes from a stalled output
  a_bp_source: assert property (@(posedge clk) disable iff (rst)
    !pair_ready |-> pix_valid && !pix_ready)
    else $error("input stalled while output drains");

  // with the output kept ready, an accepted word reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_ready ##1 pix_ready ##1 pix_ready ##1 pix_ready
      ##1 pix_ready |=> pix_valid)
    else $error("accepted word did not reach the output");

endmodule

bind rgb32_layer_blend rlb_check u_rlb_check (
  .clk        (clk),
  .rst        (rst),
  .pair_valid (pair.valid),
  .pair_ready (pair.ready),
  .pix_valid  (pix.valid),
  .pix_ready  (pix.ready),
  .out_b      (pix.out_b),
  .out_g      (pix.out_g),
  .out_r      (pix.out_r),
  .out_a      (pix.out_a)
);

### bench/testbench.sv
// self-checking bench for the rgb32 layer blender: all modes, registers and idling mixes
module testbench
  import rlb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // mode codes past the defined list; the block passes the base pixel through
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  // register index past the defined list; writes to it must change nothing
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  localparam longint HALF_STEP = 128;   // rounding term of the channel correction
  localparam longint BYTE_MAX  = 255;   // full-scale byte, used by subtract
  localparam int LONG_HOLD     = 150;   // cycles the output side holds off once
  localparam int QUIET_LIMIT   = 3000;  // cycles with no word moving before giving up
  localparam int DRAIN_CYCLES  = 12;    // pipeline is five deep, leave some margin
  localparam int PHASE_ITEMS   = 105;   // random words per configuration phase
  localparam int PHASE_COUNT   = 18;

  typedef struct packed {
    logic [PIX_W-1:0] base_b, base_g, base_r, base_a;
    logic [PIX_W-1:0] over_b, over_g, over_r, over_a;
  } pair_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] b, g, r, a;
  } pix_word_t;

  logic clk;
  logic rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rlb_pair_if pair_ch ();
  rlb_pix_if  pix_ch ();

  rgb32_layer_blend dut (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair_ch),
    .pix       (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // bench copy of the configuration registers, changed only while the block is idle
  logic [2:0]          cfg_mode;
  logic                cfg_chroma;
  logic [LEVEL_W-1:0]  cfg_level;
  logic [THRESH_W-1:0] cfg_thresh;
  logic [COEF_W-1:0]   cfg_coef_b, cfg_coef_g, cfg_coef_r;

  pair_word_t feed_queue [$];   // words waiting to be offered on pair
  pix_word_t  pix_expect [$];   // blended pixels owed by the block, oldest first

  int send_idle_pct;            // chance per cycle that the sender holds back
  int stall_pct;                // chance per cycle that the receiver drops ready
  bit long_hold_req;            // asks the ready process for one long hold-off
  int hold_left;
  bit hold_done;
  int mismatch_count;
  int fail_count;
  int quiet_cycles;
  pair_word_t drive_word;

  // weighted luma, 15-bit fixed point, no saturation
  function automatic longint luma_of(input longint b, input longint g, input longint r);
    return (longint'(cfg_coef_b) * b + longint'(cfg_coef_g) * g
            + longint'(cfg_coef_r) * r) >>> LUMA_SHIFT;
  endfunction

  // what the block should return for one pair under the current registers
  function automatic pix_word_t blended_pixel(input pair_word_t p);
    longint bse [CHAN_N];
    longint ovr [CHAN_N];
    longint wgt, y_over, y_base, y_inv, thr, s, res;
    logic [PIX_W-1:0] o [CHAN_N];
    pix_word_t q;
    bse[0] = longint'(p.base_b);
    bse[1] = longint'(p.base_g);
    bse[2] = longint'(p.base_r);
    bse[3] = longint'(p.base_a);
    ovr[0] = longint'(p.over_b);
    ovr[1] = longint'(p.over_g);
    ovr[2] = longint'(p.over_r);
    ovr[3] = longint'(p.over_a);
    thr = longint'(cfg_thresh);
    // weight from overlay alpha and global level
    wgt = (ovr[3] * longint'(cfg_level) + 1) >>> 8;
    y_over = luma_of(ovr[0], ovr[1], ovr[2]);
    y_base = luma_of(bse[0], bse[1], bse[2]);
    y_inv  = luma_of(BYTE_MAX - ovr[0], BYTE_MAX - ovr[1], BYTE_MAX - ovr[2]);
    // lighten and darken apply the weight only past the luma margin
    if (cfg_mode == MODE_LITE && !(y_over > y_base + thr)) wgt = 0;
    if (cfg_mode == MODE_DARK && !(y_over < y_base - thr)) wgt = 0;
    for (int k = 0; k < CHAN_N; k++) begin
      case (cfg_mode)
        MODE_AVG: begin
          res = (bse[k] + ovr[k] + 1) >>> 1;
        end
        MODE_MUL: begin
          s = cfg_chroma ? ovr[k] : y_over;
          res = bse[k] + (((((s * bse[k]) >>> 8) - bse[k]) * wgt) >>> 8);
        end
        MODE_ADD: begin
          s = cfg_chroma ? ovr[k] : y_over;
          res = bse[k] + (((s - bse[k]) * wgt + HALF_STEP) >>> 8);
        end
        MODE_SUB: begin
          s = cfg_chroma ? (BYTE_MAX - ovr[k]) : y_inv;
          res = bse[k] + (((s - bse[k]) * wgt + HALF_STEP) >>> 8);
        end
        MODE_LITE, MODE_DARK: begin
          res = bse[k] + (((ovr[k] - bse[k]) * wgt + HALF_STEP) >>> 8);
        end
        default: begin
          res = bse[k];
        end
      endcase
      o[k] = res[PIX_W-1:0];   // wraps modulo 256
    end
    q.b = o[0];
    q.g = o[1];
    q.r = o[2];
    q.a = o[3];
    return q;
  endfunction

  // sender: offers the next queued word, or idles at random
  always @(posedge clk) begin
    if (rst) begin
      pair_ch.valid <= 1'b0;
    end else if (!pair_ch.valid || pair_ch.ready) begin
      if (feed_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_word = feed_queue.pop_front();
        pair_ch.base_b <= drive_word.base_b;
        pair_ch.base_g <= drive_word.base_g;
        pair_ch.base_r <= drive_word.base_r;
        pair_ch.base_a <= drive_word.base_a;
        pair_ch.over_b <= drive_word.over_b;
        pair_ch.over_g <= drive_word.over_g;
        pair_ch.over_r <= drive_word.over_r;
        pair_ch.over_a <= drive_word.over_a;
        pair_ch.valid  <= 1'b1;
      end else begin
        pair_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      pix_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (long_hold_req && !hold_done) begin
      pix_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      hold_done    <= 1'b1;
    end else begin
      pix_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on every accepted pair, check every accepted pixel
  always @(posedge clk) begin
    pair_word_t got_pair;
    pix_word_t  want, got;
    logic [PIX_W-1:0] want_f [CHAN_N];
    logic [PIX_W-1:0] got_f [CHAN_N];
    string fname [CHAN_N];
    fname = '{"b", "g", "r", "a"};
    if (!rst) begin
      if (pair_ch.valid && pair_ch.ready) begin
        got_pair.base_b = pair_ch.base_b;
        got_pair.base_g = pair_ch.base_g;
        got_pair.base_r = pair_ch.base_r;
        got_pair.base_a = pair_ch.base_a;
        got_pair.over_b = pair_ch.over_b;
        got_pair.over_g = pair_ch.over_g;
        got_pair.over_r = pair_ch.over_r;
        got_pair.over_a = pair_ch.over_a;
        pix_expect.push_back(blended_pixel(got_pair));
      end
      if (pix_ch.valid && pix_ch.ready) begin
        got.b = pix_ch.out_b;
        got.g = pix_ch.out_g;
        got.r = pix_ch.out_r;
        got.a = pix_ch.out_a;
        if (pix_expect.size() == 0) begin
          // a pixel the block was never asked for
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected pixel b=%0d g=%0d r=%0d a=%0d",
                     $realtime, got.b, got.g, got.r, got.a);
        end else begin
          want = pix_expect.pop_front();
          want_f = '{want.b, want.g, want.r, want.a};
          got_f  = '{got.b, got.g, got.r, got.a};
          for (int k = 0; k < CHAN_N; k++) begin
            if (got_f[k] !== want_f[k]) begin
              fail_count++;
              mismatch_count++;
              if (mismatch_count <= 10)
                $display("[%0t] out_%0s mismatch: expected %0d, got %0d (mode %0d)",
                         $realtime, fname[k], want_f[k], got_f[k], cfg_mode);
            end
          end
        end
      end
    end
  end

  // watchdog: too long with no word moving on either channel ends the run
  always @(posedge clk) begin
    if (rst || (pair_ch.valid && pair_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one register write; the bench copy follows the same field widths
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:   cfg_mode   = val[2:0];
      REG_CHROMA: cfg_chroma = val[0];
      REG_LEVEL:  cfg_level  = val[LEVEL_W-1:0];
      REG_THRESH: cfg_thresh = val[THRESH_W-1:0];
      REG_COEF_B: cfg_coef_b = val;
      REG_COEF_G: cfg_coef_g = val;
      REG_COEF_R: cfg_coef_r = val;
      default: ;   // unknown index, ignored
    endcase
  endtask

  task automatic set_regs(input logic [2:0] mode, input logic chroma,
                          input int level, input int thresh,
                          input int cb, input int cg, input int cr);
    write_reg(REG_MODE, CFG_W'(mode));
    write_reg(REG_CHROMA, CFG_W'(chroma));
    write_reg(REG_LEVEL, CFG_W'(level));
    write_reg(REG_THRESH, CFG_W'(thresh));
    write_reg(REG_COEF_B, CFG_W'(cb));
    write_reg(REG_COEF_G, CFG_W'(cg));
    write_reg(REG_COEF_R, CFG_W'(cr));
    @(negedge clk);
  endtask

  // bytes leaning toward the ends of the range
  function automatic logic [PIX_W-1:0] pick_byte();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  // corner pixels: all dark, opaque black over white, opaque white over black,
  // and an overlay equal to the base, where lighten and darken sit on the margin
  task automatic add_corners();
    pair_word_t w;
    w = '0;
    feed_queue.push_back(w);
    w = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255};
    feed_queue.push_back(w);
    w = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    feed_queue.push_back(w);
    w = '{8'd90, 8'd160, 8'd30, 8'd7, 8'd90, 8'd160, 8'd30, 8'd200};
    feed_queue.push_back(w);
  endtask

  task automatic add_random(input int count);
    pair_word_t w;
    for (int i = 0; i < count; i++) begin
      w = {pick_byte(), pick_byte(), pick_byte(), pick_byte(),
           pick_byte(), pick_byte(), pick_byte(), pick_byte()};
      // sometimes reuse the base colors so lumas tie or sit close together
      if ($urandom_range(7) == 0) begin
        w.over_b = w.base_b;
        w.over_g = w.base_g ^ PIX_W'($urandom_range(1));
        w.over_r = w.base_r;
      end
      feed_queue.push_back(w);
    end
  endtask

  // every queued word accepted and every owed pixel returned
  task automatic wait_idle();
    while (feed_queue.size() != 0 || pair_ch.valid || pix_expect.size() != 0)
      @(negedge clk);
  endtask

  // main sequence: reset, then one phase per register setting
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    pair_ch.valid   = 1'b0;
    pair_ch.base_b  = '0;
    pair_ch.base_g  = '0;
    pair_ch.base_r  = '0;
    pair_ch.base_a  = '0;
    pair_ch.over_b  = '0;
    pair_ch.over_g  = '0;
    pair_ch.over_r  = '0;
    pair_ch.over_a  = '0;
    pix_ch.ready    = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    long_hold_req   = 1'b0;
    mismatch_count  = 0;
    fail_count      = 0;
    cfg_mode        = RST_MODE;
    cfg_chroma      = RST_CHROMA;
    cfg_level       = RST_LEVEL;
    cfg_thresh      = RST_THRESH;
    cfg_coef_b      = RST_COEF_B;
    cfg_coef_g      = RST_COEF_G;
    cfg_coef_r      = RST_COEF_R;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: add with overlay luma
    add_corners();
    add_random(100);
    wait_idle();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:  set_regs(MODE_AVG, 1'b1, 257, 0, RST_COEF_B, RST_COEF_G, RST_COEF_R);
        1:  set_regs(MODE_MUL, 1'b0, 257, 0, RST_COEF_B, RST_COEF_G, RST_COEF_R);
        2:  set_regs(MODE_MUL, 1'b1, 511, 0, RST_COEF_B, RST_COEF_G, RST_COEF_R);
        3:  set_regs(MODE_ADD, 1'b1, 0, 0, RST_COEF_B, RST_COEF_G, RST_COEF_R);
        4:  set_regs(MODE_SUB, 1'b0, 300, 0, 32768, 32768, 32768);
        5:  set_regs(MODE_SUB, 1'b1, 128, 0, RST_COEF_B, RST_COEF_G, RST_COEF_R);
        // chroma flag set but ignored by lighten
        6:  set_regs(MODE_LITE, 1'b1, 257, 0, RST_COEF_B, RST_COEF_G, RST_COEF_R);
        // largest coefficients push luma past a byte
        7:  set_regs(MODE_LITE, 1'b0, 511, 40, 65535, 65535, 65535);
        8:  set_regs(MODE_DARK, 1'b0, 257, 255, RST_COEF_B, RST_COEF_G, RST_COEF_R);
        9:  set_regs(MODE_DARK, 1'b1, 200, 10, 0, 65535, 1000);
        10: set_regs(MODE_SPARE6, 1'b1, 257, 0, RST_COEF_B, RST_COEF_G, RST_COEF_R);
        11: begin
          set_regs(MODE_SPARE7, 1'b0, 257, 0, RST_COEF_B, RST_COEF_G, RST_COEF_R);
          // stray write to an unused index, then back to add: must not disturb it
          write_reg(REG_NONE, '1);
          write_reg(REG_MODE, CFG_W'(MODE_ADD));
          @(negedge clk);
        end
        default: set_regs(3'($urandom_range(7)), 1'($urandom_range(1)),
                          $urandom_range(511), $urandom_range(255),
                          $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535));
      endcase

      // rotate through the idling mixes
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      // full-rate sender against a receiver that goes quiet: the pipe fills and
      // pair ready has to drop
      if (ph == 4) long_hold_req = 1'b1;

      if (ph < 6) add_corners();
      add_random(PHASE_ITEMS);
      wait_idle();
    end

    // let any stray pixel show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pix_expect.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
